[rtl/compass_heading_with_offset_assert.svh]
// Assertion macros for the compass heading block.
// Used by the CORDIC cell and the top level; needs clk_i and rst_ni in scope.
`ifndef COMPASS_HEADING_WITH_OFFSET_ASSERT_SVH
`define COMPASS_HEADING_WITH_OFFSET_ASSERT_SVH
`ifndef SYNTHESIS
`define CHWO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CHWO_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);
`else
`define CHWO_ASSERT(lbl, prop, msg)
`define CHWO_ASSERT_NEXT(lbl, trig, prop, msg)
`endif
`endif

[rtl/chwo_pkg.sv]
// Package for the compass heading block: widths, CORDIC angle table, request types.
// No dependencies; imported by every module of the block.
`default_nettype none

package chwo_pkg;

  localparam int CORDIC_STAGES       = 16;
  localparam int ANGLE_FRACTION_BITS = 7;
  localparam int INNER_BITS          = 24;
  localparam int MAX_STAGES          = 24;
  localparam int STAGE_W             = 5;
  localparam int FIELD_W             = 16;
  localparam int HEADING_W           = 16;
  localparam int XY_W                = FIELD_W + INNER_BITS + 2;
  localparam int Z_W                 = 34;
  localparam int ROUND_SHIFT         = INNER_BITS - ANGLE_FRACTION_BITS;
  localparam int OFF_MAX_DEG         = ((2 ** HEADING_W - 1) >> ANGLE_FRACTION_BITS) + 1;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_HEADING_OFFSET = '0;

  function automatic int red_stages();
    int n;
    n = 1;
    while ((360 << (n - 1)) < (OFF_MAX_DEG + 280)) begin
      n++;
    end
    return n;
  endfunction

  localparam int RED_N    = red_stages();
  localparam int RED_W    = $clog2(RED_N + 1);
  localparam int H_W      = RED_N + 33;
  localparam int Q_W      = ANGLE_FRACTION_BITS + 9;

  localparam logic [H_W-1:0] FULL_H = H_W'(360) << INNER_BITS;
  localparam logic [H_W-1:0] K_FULL = FULL_H << (RED_N - 1);
  localparam logic [H_W-1:0] HALF_H = H_W'(1) << (ROUND_SHIFT - 1);
  localparam logic [Q_W-1:0] Q_FULL = Q_W'(360) << ANGLE_FRACTION_BITS;
  localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(180) <<< INNER_BITS;

  localparam logic signed [Z_W-1:0] ATAN_TAB [MAX_STAGES] = '{
    Z_W'(754974720), Z_W'(445687602), Z_W'(235489088), Z_W'(119537938),
    Z_W'(60000934),  Z_W'(30029717),  Z_W'(15018523),  Z_W'(7509720),
    Z_W'(3754917),   Z_W'(1877466),   Z_W'(938734),    Z_W'(469367),
    Z_W'(234684),    Z_W'(117342),    Z_W'(58671),     Z_W'(29335),
    Z_W'(14668),     Z_W'(7334),      Z_W'(3667),      Z_W'(1833),
    Z_W'(917),       Z_W'(458),       Z_W'(229),       Z_W'(115)
  };

  typedef struct packed {
    logic                   zero;
    logic signed [Z_W-1:0]  z;
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] x;
  } cordic_t;

endpackage

`default_nettype wire

[rtl/chwo_cordic_cell.sv]
// One CORDIC vectoring stage with its own request register and ready chain.
// Depends on chwo_pkg and the assertion macro header.
`default_nettype none
`include "compass_heading_with_offset_assert.svh"

module chwo_cordic_cell import chwo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [STAGE_W-1:0] stage_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cordic_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cordic_t            out_data_o
);

  logic    valid_q;
  cordic_t data_q, data_d;
  logic    load;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    logic signed [XY_W-1:0] x, y, dx, dy;
    logic signed [Z_W-1:0]  z, a;
    x  = in_data_i.x;
    y  = in_data_i.y;
    z  = in_data_i.z;
    dx = y >>> stage_i;
    dy = x >>> stage_i;
    a  = ATAN_TAB[stage_i];
    data_d.zero = in_data_i.zero;
    if (y > 0) begin
      data_d.x = x + dx;
      data_d.y = y - dy;
      data_d.z = z + a;
    end else begin
      data_d.x = x - dx;
      data_d.y = y + dy;
      data_d.z = z - a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  `CHWO_ASSERT(a_x_nonneg, valid_q |-> !data_q.x[XY_W-1], "CORDIC x went negative")
  `CHWO_ASSERT_NEXT(a_hold, valid_q && !out_ready_i, valid_q && $stable(data_q),
                    "stalled request changed in cell")
  `CHWO_ASSERT_NEXT(a_drain, valid_q && out_ready_i && !in_valid_i, !valid_q,
                    "request repeated in cell")

endmodule

`default_nettype wire

[rtl/chwo_wrap_cell.sv]
// One modulo-360 reduction step: subtract 2^step full turns when the angle allows it.
// Depends on chwo_pkg.
`default_nettype none

module chwo_wrap_cell import chwo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [RED_W-1:0] step_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [H_W-1:0]   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [H_W-1:0]   out_data_o
);

  logic           valid_q;
  logic [H_W-1:0] data_q, data_d, amt;
  logic           load;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign amt         = FULL_H << step_i;
  assign data_d      = (in_data_i >= amt) ? (in_data_i - amt) : in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

[rtl/compass_heading_with_offset.sv]
// Top level of the compass heading block: input prep, CORDIC cell chain, offset,
// modulo-360 cells, rounding, output register and APB offset register.
// Depends on chwo_pkg, chwo_cordic_cell, chwo_wrap_cell and the assertion header.
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i/in_stall_o   field_x_i, field_y_i
//   out       source     out_valid_o/out_stall_i heading_o
//   apb       sink       psel/penable/pwrite     paddr, pwdata, prdata
//
// One request per cycle while out_stall_i does not hold the chain; each request is registered
// in every CORDIC cell, the offset register, every modulo-360 cell and the output register.
// Reset clears every stage valid and the offset register.
// Each stage holds while the one after it is full and stalled; empty stages still fill.
`default_nettype none
`include "compass_heading_with_offset_assert.svh"

module compass_heading_with_offset import chwo_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [FIELD_W-1:0]  field_x_i,
  input  logic signed [FIELD_W-1:0]  field_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic        [HEADING_W-1:0] heading_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic        [PADDR_W-1:0]  paddr,
  input  logic        [PDATA_W-1:0]  pwdata,
  output logic        [PDATA_W-1:0]  prdata,
  output logic                       pready
);

  logic [HEADING_W-1:0] offset_q;
  logic                 reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_HEADING_OFFSET);
  assign prdata  = reg_hit ? PDATA_W'(offset_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      offset_q <= pwdata[HEADING_W-1:0];
    end
  end

  cordic_t c_data  [CORDIC_STAGES+1];
  logic    c_valid [CORDIC_STAGES+1];
  logic    c_ready [CORDIC_STAGES+1];
  cordic_t prep;

  always_comb begin
    logic signed [XY_W-1:0] xs, ys;
    xs = XY_W'(field_x_i) <<< INNER_BITS;
    ys = XY_W'(field_y_i) <<< INNER_BITS;
    prep.zero = (field_x_i == '0) && (field_y_i == '0);
    if (xs < 0) begin
      prep.x = -xs;
      prep.y = -ys;
      prep.z = (ys >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
    end else begin
      prep.x = xs;
      prep.y = ys;
      prep.z = '0;
    end
  end

  assign c_data[0]  = prep;
  assign c_valid[0] = in_valid_i;
  assign in_stall_o = !c_ready[0];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    chwo_cordic_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .stage_i     (STAGE_W'(g)),
      .in_valid_i  (c_valid[g]),
      .in_ready_o  (c_ready[g]),
      .in_data_i   (c_data[g]),
      .out_valid_o (c_valid[g+1]),
      .out_ready_i (c_ready[g+1]),
      .out_data_o  (c_data[g+1])
    );
  end

  logic           w_valid [RED_N+1];
  logic           w_ready [RED_N+1];
  logic [H_W-1:0] w_data  [RED_N+1];
  logic           off_valid_q;
  logic [H_W-1:0] off_h_q, off_h_d, z_ext, off_ext;

  assign z_ext   = c_data[CORDIC_STAGES].zero ? '0 : H_W'(c_data[CORDIC_STAGES].z);
  assign off_ext = H_W'(offset_q) << ROUND_SHIFT;
  assign off_h_d = z_ext + K_FULL - off_ext;
  assign c_ready[CORDIC_STAGES] = !off_valid_q || w_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_valid_q <= 1'b0;
    end else if (c_ready[CORDIC_STAGES]) begin
      off_valid_q <= c_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid[CORDIC_STAGES] && c_ready[CORDIC_STAGES]) begin
      off_h_q <= off_h_d;
    end
  end

  assign w_valid[0] = off_valid_q;
  assign w_data[0]  = off_h_q;

  for (genvar k = 0; k < RED_N; k++) begin : g_wrap
    chwo_wrap_cell u_wrap (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (RED_W'(RED_N - 1 - k)),
      .in_valid_i  (w_valid[k]),
      .in_ready_o  (w_ready[k]),
      .in_data_i   (w_data[k]),
      .out_valid_o (w_valid[k+1]),
      .out_ready_i (w_ready[k+1]),
      .out_data_o  (w_data[k+1])
    );
  end

  logic           out_valid_q;
  logic [Q_W-1:0] q_q, q_d;
  logic [H_W-1:0] rounded;

  assign rounded       = w_data[RED_N] + HALF_H;
  assign q_d           = (Q_W'(rounded >> ROUND_SHIFT) >= Q_FULL) ? '0
                                                                  : Q_W'(rounded >> ROUND_SHIFT);
  assign w_ready[RED_N] = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (w_ready[RED_N]) begin
      out_valid_q <= w_valid[RED_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_valid[RED_N] && w_ready[RED_N]) begin
      q_q <= q_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign heading_o   = HEADING_W'(q_q);

  `CHWO_ASSERT_NEXT(a_off_write, psel && penable && pwrite && reg_hit,
                    offset_q == $past(pwdata[HEADING_W-1:0]), "offset write lost")
  `CHWO_ASSERT(a_wrap_range, w_valid[RED_N] |-> (w_data[RED_N] < FULL_H),
               "angle not reduced below a full turn")
  `CHWO_ASSERT(a_head_range, out_valid_q |-> (q_q < Q_FULL), "heading out of range")

endmodule

`default_nettype wire

[tb/sv/tb_compass_heading_with_offset.sv]
// Self-checking testbench for compass_heading_with_offset: feeds X/Y field samples, predicts
// each heading with a fixed-point CORDIC model and compares the returned headings in order.
// Depends on chwo_pkg and the compass_heading_with_offset RTL.
`default_nettype none

module tb_compass_heading_with_offset;
  import chwo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES = CORDIC_STAGES + 16;
  localparam logic [PADDR_W-1:0] ADDR_HEADING_OFFSET = PADDR_W'(4 * REG_HEADING_OFFSET);
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = PADDR_W'(4);

  localparam longint ATAN_DEG [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  typedef struct {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
  } sample_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall_o;
  logic signed [FIELD_W-1:0]   field_x = '0;
  logic signed [FIELD_W-1:0]   field_y = '0;
  logic                        out_valid_o;
  logic                        out_stall = 1'b0;
  logic        [HEADING_W-1:0] heading_o;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic        [PADDR_W-1:0]   paddr = '0;
  logic        [PDATA_W-1:0]   pwdata = '0;
  logic        [PDATA_W-1:0]   prdata;
  logic                        pready;

  sample_t                     sample_q[$];
  logic        [HEADING_W-1:0] heading_q[$];
  logic        [15:0]          offset_cfg = '0;
  bit                          send_idle = 1'b0;
  bit                          recv_idle = 1'b0;
  int                          hold_asks = 0;
  int                          hold_done = 0;
  int                          gap_left = 0;
  int                          stall_left = 0;
  int                          accepted_cnt = 0;
  int                          checked_cnt = 0;
  int                          error_cnt = 0;
  int                          offset_writes = 0;

  compass_heading_with_offset u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .field_x_i   (field_x),
    .field_y_i   (field_y),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .heading_o   (heading_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  function automatic logic [HEADING_W-1:0] azimuth_heading(
    logic signed [FIELD_W-1:0] fx,
    logic signed [FIELD_W-1:0] fy,
    logic        [15:0]        off
  );
    longint x, y, z, dx, dy, h, full;
    longint unsigned q;
    int shift;
    shift = INNER_BITS - ANGLE_FRACTION_BITS;
    full = longint'(360) << INNER_BITS;
    x = longint'(fx);
    y = longint'(fy);
    z = 0;
    if (x != 0 || y != 0) begin
      x = x * (longint'(1) << INNER_BITS);
      y = y * (longint'(1) << INNER_BITS);
      if (x < 0) begin
        z = (y >= 0) ? (longint'(180) << INNER_BITS) : -(longint'(180) << INNER_BITS);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_DEG[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_DEG[i];
        end
      end
    end
    h = z - (longint'(off) << shift);
    h = h % full;
    if (h < 0) h = h + full;
    q = (longint'(h) + (longint'(1) << (shift - 1))) >> shift;
    if (q >= (longint'(360) << ANGLE_FRACTION_BITS)) q = 0;
    return q[HEADING_W-1:0];
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int r;
    logic signed [FIELD_W-1:0] ext [6];
    ext = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff};
    r = $urandom_range(0, 99);
    s.x = FIELD_W'($urandom);
    s.y = FIELD_W'($urandom);
    if (r >= 40 && r < 55) begin
      s.x = FIELD_W'($urandom_range(0, 8) - 4);
      s.y = FIELD_W'($urandom_range(0, 8) - 4);
    end else if (r >= 55 && r < 70) begin
      if ($urandom_range(0, 1)) s.x = '0;
      else s.y = '0;
    end else if (r >= 70 && r < 85) begin
      s.y = ($urandom_range(0, 1) ? s.x : -s.x) + FIELD_W'($urandom_range(0, 4) - 2);
    end else if (r >= 85 && r < 95) begin
      s.x = ext[$urandom_range(0, 5)];
      s.y = ext[$urandom_range(0, 5)];
    end else if (r >= 95) begin
      s.x = '0;
      s.y = '0;
    end
    return s;
  endfunction

  task automatic add_sample(int x, int y);
    sample_t s;
    s.x = FIELD_W'(x);
    s.y = FIELD_W'(y);
    sample_q.push_back(s);
  endtask

  task automatic add_random(int n);
    repeat (n) sample_q.push_back(rand_sample());
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid || heading_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_HEADING_OFFSET) begin
      offset_cfg = data[15:0];
      offset_writes++;
    end
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // request driver: hold while stalled, advance on acceptance
  always @(posedge clk_i) begin
    sample_t s;
    logic take;
    if (rst_ni) begin
      take = in_valid && !in_stall_o;
      if (take) begin
        heading_q.push_back(azimuth_heading(field_x, field_y, offset_cfg));
        accepted_cnt++;
      end
      if (!in_valid || take) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          s = sample_q.pop_front();
          field_x  <= s.x;
          field_y  <= s.y;
          in_valid <= 1'b1;
          gap_left = send_idle ? rand_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic nxt;
    if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b1;
    end else if (recv_idle && $urandom_range(0, 99) < 20) begin
      stall_left = rand_gap();
      nxt = 1'b1;
    end else begin
      nxt = 1'b0;
    end
    out_stall <= nxt;
  end

  always @(posedge clk_i) begin
    logic [HEADING_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (heading_q.size() == 0) begin
        $display("%0t: unexpected heading, expected none, actual %0d", $time, heading_o);
        error_cnt++;
      end else begin
        want = heading_q.pop_front();
        checked_cnt++;
        if (heading_o !== want) begin
          $display("%0t: heading mismatch, expected %0d, actual %0d", $time, want, heading_o);
          error_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_sample(0, 0);
    add_sample(32767, 0);
    add_sample(-32768, 0);
    add_sample(0, 32767);
    add_sample(0, -32768);
    add_sample(32767, 32767);
    add_sample(-32768, -32768);
    add_sample(-32768, 32767);
    add_sample(32767, -32768);
    add_sample(-1, 0);
    add_sample(-1, -1);
    add_sample(-1, 1);
    add_sample(1, -1);
    add_sample(1, 1);
    add_sample(0, 1);
    add_sample(0, -1);
    add_sample(1, 0);
    add_sample(-5, 0);
    add_sample(-32767, -1);
    add_sample(12345, -23456);
    wait_idle();

    apb_write(ADDR_HEADING_OFFSET, 32'd46079);
    add_sample(0, 0);
    add_sample(32767, 0);
    add_sample(-32768, 0);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    add_random(200);
    wait_idle();

    apb_write(ADDR_HEADING_OFFSET, 32'h1234_ffff);
    apb_write(ADDR_UNMAPPED, 32'd123);
    add_sample(0, 0);
    add_random(60);
    wait_idle();
    send_idle = 1'b0;
    hold_asks++;
    add_random(140);
    wait_idle();

    apb_write(ADDR_HEADING_OFFSET, 32'd0);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    add_random(150);
    wait_idle();

    apb_write(ADDR_HEADING_OFFSET, PDATA_W'($urandom_range(0, 46079)));
    send_idle = 1'b1;
    recv_idle = 1'b1;
    add_random(100);
    wait_idle();
    add_random(100);
    wait_idle();

    apb_write(ADDR_HEADING_OFFSET, 32'd1);
    add_sample(0, 0);
    add_random(170);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d samples and %0d checked headings over %0d offset settings,",
             accepted_cnt, checked_cnt, offset_writes + 1);
    $display("including extremes, zero vectors, long output back-pressure and idle gaps.");
    if (error_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/chwo_pkg.sv
rtl/chwo_cordic_cell.sv
rtl/chwo_wrap_cell.sv
rtl/compass_heading_with_offset.sv
tb/sv/tb_compass_heading_with_offset.sv
